// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// Each macro samples on a rising clock edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every sampled edge.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// A condition at one edge requires a consequence at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/phm_pkg.sv -----
// Package for the polynomial hash block: widths, stage record and shared helpers.
// Used by the cells and the top level; depends on nothing.
`timescale 1ns / 1ps

package phm_pkg;

    localparam int DIGITS = 5;
    localparam int VEC_W  = 5;
    localparam int W      = 24;
    // One entry stage, then per Horner round W multiply steps and one add step.
    localparam int NSTAGE = 1 + (DIGITS - 1) * (W + 1);

    localparam logic REG_MODULUS = 1'b0;
    localparam logic REG_BASE    = 1'b1;

    localparam logic [W-1:0] MODULUS_RESET = W'(1000003);
    localparam logic [W-1:0] BASE_RESET    = W'(31);

    typedef struct packed {
        logic             valid;
        logic [VEC_W-1:0] vec;
        logic [W-1:0]     acc;
        logic [W-1:0]     r;
    } stage_t;

    // Digits beyond the input field read as zero.
    function automatic logic digit_bit(input logic [VEC_W-1:0] v, input int idx);
        logic b;
        b = 1'b0;
        for (int j = 0; j < VEC_W; j++) begin
            if (j == idx) begin
                b = v[j];
            end
        end
        return b;
    endfunction

    // (digit + 1) reduced mod m; the coefficient is only 1 or 2.
    function automatic logic [W-1:0] coef_mod(input logic d, input logic [W-1:0] m);
        logic [W-1:0] c;
        logic [W-1:0] diff;
        c    = {{(W-2){1'b0}}, d, ~d};
        diff = c;
        if (c >= m) begin
            diff = c - m;
            if (diff >= m) begin
                diff = '0;
            end
        end
        return diff;
    endfunction

endpackage

// ----- rtl/phm_mul_cell.sv -----
// One step of an interleaved modular multiply: r <= (2r + bit * acc) mod m.
// Depends on phm_pkg for the stage record and widths.
`timescale 1ns / 1ps

module phm_mul_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic [phm_pkg::W-1:0] modulus,
    input  logic                  base_bit,
    input  phm_pkg::stage_t       st_in,
    output phm_pkg::stage_t       st_out
);

    localparam int TW = phm_pkg::W + 2;

    phm_pkg::stage_t st_reg;
    phm_pkg::stage_t st_next;
    logic [TW-1:0]   t;
    logic [TW-1:0]   m1;
    logic [TW-1:0]   m2;
    logic [TW-1:0]   red;

    // With r and acc below m the sum stays below 3m, so two trial subtractions do.
    always_comb begin
        t  = {1'b0, st_in.r, 1'b0} + {2'b00, (base_bit ? st_in.acc : '0)};
        m1 = {2'b00, modulus};
        m2 = {1'b0, modulus, 1'b0};
        priority if (t >= m2) begin
            red = t - m2;
        end else if (t >= m1) begin
            red = t - m1;
        end else begin
            red = t;
        end
        st_next       = st_in;
        st_next.r     = red[phm_pkg::W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else if (en) begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule

// ----- rtl/phm_add_cell.sv -----
// Closing step of a Horner round: acc <= (r + digit + 1) mod m, product cleared.
// Depends on phm_pkg for the stage record and the coefficient helper.
`timescale 1ns / 1ps

module phm_add_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic [phm_pkg::W-1:0] modulus,
    input  logic                  digit,
    input  phm_pkg::stage_t       st_in,
    output phm_pkg::stage_t       st_out
);

    phm_pkg::stage_t         st_reg;
    phm_pkg::stage_t         st_next;
    logic [phm_pkg::W:0]     s;
    logic [phm_pkg::W:0]     sred;

    always_comb begin
        s = {1'b0, st_in.r} + {1'b0, phm_pkg::coef_mod(digit, modulus)};
        if (s >= {1'b0, modulus}) begin
            sred = s - {1'b0, modulus};
        end else begin
            sred = s;
        end
        st_next     = st_in;
        st_next.acc = sred[phm_pkg::W-1:0];
        st_next.r   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else if (en) begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule

// ----- rtl/polynomial_hash_mod_m.sv -----
// Top level of the polynomial hash block: registers, cell chain, output buffer.
// Depends on phm_pkg, phm_mul_cell and phm_add_cell.
`timescale 1ns / 1ps

// Usage:
//   Input items arrive on s_valid / s_ready with s_digit_vector; each gives one
//   result on m_valid / m_ready with m_hash_value, in the order taken.
//   cfg_we writes cfg_data to the modulus (index 0) or the base (index 1);
//   write only while no item is in flight.
//   The hash is evaluated by Horner's rule, most significant digit first. Each
//   round multiplies by the base through a row of W = 24 one-bit cells and then
//   adds the next digit in one more cell, so the chain has 1 + (DIGITS-1)*25
//   registered stages. The accepting edge loads the entry stage; one item is
//   taken every cycle while s_ready is high.
//   A two-entry output buffer sits after the chain. The chain advances while
//   the buffer has room, so items keep entering while one result waits; when
//   both entries are held the whole chain pauses and s_ready drops.
//   Reset empties the chain and the buffer and loads modulus 1000003, base 31.
//   A modulus of zero gives a hash of zero.

module polynomial_hash_mod_m (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [phm_pkg::VEC_W-1:0] s_digit_vector,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [phm_pkg::W-1:0]     m_hash_value,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [phm_pkg::W-1:0]     cfg_data
);

    localparam int W  = phm_pkg::W;
    localparam int RW = W + 1;

    logic [W-1:0]    modulus_reg;
    logic [W-1:0]    base_reg;
    phm_pkg::stage_t st [phm_pkg::NSTAGE];
    phm_pkg::stage_t st0_reg;
    phm_pkg::stage_t st0_next;
    logic            adv;
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    logic [W-1:0]    head_reg;
    logic [W-1:0]    head_next;
    logic [W-1:0]    spare_reg;
    logic [W-1:0]    spare_next;
    logic            push;
    logic            pop;
    logic [W-1:0]    result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= phm_pkg::MODULUS_RESET;
            base_reg    <= phm_pkg::BASE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                phm_pkg::REG_MODULUS: modulus_reg <= cfg_data;
                phm_pkg::REG_BASE:    base_reg    <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign adv     = (cnt_reg != 2'd2);
    assign s_ready = adv;

    // Entry stage: the top digit seeds the accumulator.
    always_comb begin
        st0_next.valid = s_valid;
        st0_next.vec   = s_digit_vector;
        st0_next.acc   = phm_pkg::coef_mod(
            phm_pkg::digit_bit(s_digit_vector, phm_pkg::DIGITS - 1), modulus_reg);
        st0_next.r     = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_reg.valid <= 1'b0;
        end else if (adv) begin
            st0_reg <= st0_next;
        end
    end

    assign st[0] = st0_reg;

    for (genvar k = 0; k < phm_pkg::DIGITS - 1; k++) begin : g_round
        for (genvar j = 0; j < W; j++) begin : g_bit
            phm_mul_cell u_mul (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (adv),
                .modulus  (modulus_reg),
                .base_bit (base_reg[W-1-j]),
                .st_in    (st[k*RW + j]),
                .st_out   (st[k*RW + j + 1])
            );
        end
        phm_add_cell u_add (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .modulus (modulus_reg),
            .digit   (phm_pkg::digit_bit(st[k*RW + W].vec, phm_pkg::DIGITS - 2 - k)),
            .st_in   (st[k*RW + W]),
            .st_out  (st[k*RW + W + 1])
        );
    end

    assign result = (modulus_reg == '0) ? '0 : st[phm_pkg::NSTAGE-1].acc;
    assign push   = adv && st[phm_pkg::NSTAGE-1].valid;
    assign pop    = m_valid && m_ready;

    always_comb begin
        cnt_next   = cnt_reg;
        head_next  = head_reg;
        spare_next = spare_reg;
        unique case (cnt_reg)
            2'd0: begin
                if (push) begin
                    head_next = result;
                    cnt_next  = 2'd1;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    head_next = result;
                end else if (push) begin
                    spare_next = result;
                    cnt_next   = 2'd2;
                end else if (pop) begin
                    cnt_next = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    head_next = spare_reg;
                    cnt_next  = 2'd1;
                end
            end
            default: cnt_next = 2'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

    assign m_valid      = (cnt_reg != 2'd0);
    assign m_hash_value = head_reg;

endmodule

// ----- rtl/phm_checker.sv -----
// Port-level checks for the polynomial hash block, bound to its top level.
// Depends on assert_macros.svh and phm_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module phm_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic [phm_pkg::VEC_W-1:0] s_digit_vector,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [phm_pkg::W-1:0]     m_hash_value,
    input logic                      cfg_we,
    input logic                      cfg_index,
    input logic [phm_pkg::W-1:0]     cfg_data
);

    logic unused_inputs;
    assign unused_inputs = s_valid ^ (^s_digit_vector) ^ cfg_we ^ cfg_index ^ (^cfg_data);

    // Input side only backs up when a result is already waiting.
    `ASSERT_ALWAYS(a_ready_when_empty, aclk, aresetn, m_valid || s_ready)
    // A full buffer that is not drained keeps the input side closed.
    `ASSERT_NEXT(a_full_holds, aclk, aresetn, m_valid && !m_ready && !s_ready, !s_ready)
    `ASSERT_NEXT(a_out_valid_holds, aclk, aresetn, m_valid && !m_ready, m_valid)
    `ASSERT_NEXT(a_out_data_holds, aclk, aresetn, m_valid && !m_ready, $stable(m_hash_value))

endmodule

bind polynomial_hash_mod_m phm_checker u_phm_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_digit_vector (s_digit_vector),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_hash_value   (m_hash_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
);

// ----- tb/tb_polynomial_hash_mod_m.sv -----
// Self-checking testbench for polynomial_hash_mod_m: a directed table of items and register
// settings, then random phases of bursty items against an in-bench hash predictor.
// Depends on phm_pkg and the polynomial_hash_mod_m RTL.
`timescale 1ns / 1ps

module tb_polynomial_hash_mod_m;

    localparam int W      = phm_pkg::W;
    localparam int VEC_W  = phm_pkg::VEC_W;
    localparam int DIGITS = phm_pkg::DIGITS;

    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 120;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 120;
    localparam logic [W-1:0] W_MAX = {W{1'b1}};

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic             idx;
        logic [W-1:0]     data;
        logic [VEC_W-1:0] vec;
        logic             known;
        logic [W-1:0]     hash;
    } step_t;

    localparam int NSTEPS = 31;
    localparam step_t DIRECTED [0:NSTEPS-1] = '{
        // Reset values: modulus 1000003, base 31.
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b00000, 1'b1, 24'd954305},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b11111, 1'b1, 24'd908607},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b00001, 1'b0, 24'd0},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b10000, 1'b0, 24'd0},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b01010, 1'b0, 24'd0},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b10101, 1'b0, 24'd0},
        // A modulus of one, and the out-of-range modulus of zero, both give zero.
        '{ROW_CFG,  phm_pkg::REG_MODULUS, 24'd1, 5'b00000, 1'b0, 24'd0},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b00000, 1'b1, 24'd0},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b11111, 1'b1, 24'd0},
        '{ROW_CFG,  phm_pkg::REG_MODULUS, 24'd0, 5'b00000, 1'b0, 24'd0},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b01101, 1'b1, 24'd0},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b11111, 1'b1, 24'd0},
        // Largest modulus; base zero leaves only digit 0.
        '{ROW_CFG,  phm_pkg::REG_MODULUS, W_MAX, 5'b00000, 1'b0, 24'd0},
        '{ROW_CFG,  phm_pkg::REG_BASE,    24'd0, 5'b00000, 1'b0, 24'd0},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b00000, 1'b1, 24'd1},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b11111, 1'b1, 24'd2},
        '{ROW_CFG,  phm_pkg::REG_BASE,    24'd1, 5'b00000, 1'b0, 24'd0},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b00000, 1'b1, 24'd5},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b11111, 1'b1, 24'd10},
        // A base equal to the modulus reduces to zero.
        '{ROW_CFG,  phm_pkg::REG_BASE,    W_MAX, 5'b00000, 1'b0, 24'd0},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b11111, 1'b1, 24'd2},
        // Base above the modulus: 0xFFFFFF mod 0xFFFFFD is 2.
        '{ROW_CFG,  phm_pkg::REG_MODULUS, 24'hFFFFFD, 5'b00000, 1'b0, 24'd0},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b00000, 1'b1, 24'd31},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b11111, 1'b1, 24'd62},
        // Base of modulus minus one alternates the sign of each weight.
        '{ROW_CFG,  phm_pkg::REG_BASE,    24'hFFFFFC, 5'b00000, 1'b0, 24'd0},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b00000, 1'b1, 24'd1},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b00110, 1'b0, 24'd0},
        '{ROW_CFG,  phm_pkg::REG_MODULUS, 24'd7, 5'b00000, 1'b0, 24'd0},
        '{ROW_CFG,  phm_pkg::REG_BASE,    24'd10, 5'b00000, 1'b0, 24'd0},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b10011, 1'b0, 24'd0},
        '{ROW_ITEM, phm_pkg::REG_MODULUS, 24'd0, 5'b00000, 1'b0, 24'd0}
    };

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [VEC_W-1:0] s_digit_vector = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [W-1:0]     m_hash_value;
    logic             cfg_we = 1'b0;
    logic             cfg_index = phm_pkg::REG_MODULUS;
    logic [W-1:0]     cfg_data = '0;

    polynomial_hash_mod_m uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_digit_vector (s_digit_vector),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_value   (m_hash_value),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [W-1:0] hash_expected_q [$];
    logic [W-1:0] cur_modulus = phm_pkg::MODULUS_RESET;
    logic [W-1:0] cur_base    = phm_pkg::BASE_RESET;
    logic [W-1:0] want;
    logic         valid_up = 1'b0;
    int errors = 0;
    int results_checked = 0;
    int items_sent = 0;
    int settings_used = 1;
    int idle_cycles = 0;
    int rx_left = 0;

    // Horner-free evaluation: each term reduced as it is added, powers reduced as they grow.
    function automatic logic [W-1:0] hash_of(input logic [VEC_W-1:0] vec,
                                             input logic [W-1:0] m,
                                             input logic [W-1:0] b);
        logic [63:0] acc;
        logic [63:0] pw;
        logic [63:0] bm;
        logic [63:0] dig;
        logic [63:0] wide_vec;
        acc = 0;
        pw = 1;
        wide_vec = 64'(vec);
        if (m == '0) begin
            return '0;
        end
        bm = 64'(b) % 64'(m);
        for (int i = 0; i < DIGITS; i++) begin
            dig = (i < VEC_W) ? ((wide_vec >> i) & 64'd1) : 64'd0;
            acc = (acc + (dig + 64'd1) * pw) % 64'(m);
            pw = (pw * bm) % 64'(m);
        end
        return acc[W-1:0];
    endfunction

    function automatic logic [W-1:0] pick_modulus();
        case ($urandom_range(0, 7))
            0: return 24'd1;
            1: return W_MAX;
            2: return W'($urandom_range(2, 16));
            3: return '0;
            4: return phm_pkg::MODULUS_RESET;
            default: return W'($urandom);
        endcase
    endfunction

    function automatic logic [W-1:0] pick_base(input logic [W-1:0] m);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 24'd1;
            2: return W_MAX;
            3: return m - 24'd1;
            4: return m + W'($urandom_range(0, 20));
            5: return W'($urandom_range(2, 40));
            default: return W'($urandom);
        endcase
    endfunction

    task automatic log_failure(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("%s", msg);
        end
    endtask

    task automatic send_item(input logic [VEC_W-1:0] vec, input logic known,
                             input logic [W-1:0] known_hash);
        s_valid <= 1'b1;
        s_digit_vector <= vec;
        valid_up = 1'b1;
        do @(posedge aclk); while (!s_ready);
        hash_expected_q.push_back(known ? known_hash : hash_of(vec, cur_modulus, cur_base));
        items_sent++;
    endtask

    task automatic stop_sending();
        if (valid_up) begin
            s_valid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    // Every item yields a result, so an empty queue means the chain is empty too.
    task automatic drain_results();
        while (hash_expected_q.size() != 0) begin
            @(posedge aclk);
        end
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == phm_pkg::REG_MODULUS) begin
            cur_modulus = data;
        end else begin
            cur_base = data;
        end
        settings_used++;
        @(posedge aclk);
    endtask

    // Receiver alternates ready runs, some of them long, with short stalls.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            if (m_ready) begin
                m_ready <= 1'b0;
                rx_left <= $urandom_range(1, 12);
            end else begin
                m_ready <= 1'b1;
                rx_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 20);
            end
        end else begin
            rx_left <= rx_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (hash_expected_q.size() == 0) begin
                log_failure($sformatf("Unexpected result: hash %0d", m_hash_value));
            end else begin
                want = hash_expected_q.pop_front();
                if (m_hash_value !== want) begin
                    log_failure($sformatf("Hash mismatch: expected %0d, got %0d",
                                          want, m_hash_value));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int burst;
        int gap;
        int items_left;
        logic [W-1:0] new_mod;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < NSTEPS; r++) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                stop_sending();
                drain_results();
                write_reg(DIRECTED[r].idx, DIRECTED[r].data);
            end else begin
                send_item(DIRECTED[r].vec, DIRECTED[r].known, DIRECTED[r].hash);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            stop_sending();
            drain_results();
            new_mod = pick_modulus();
            write_reg(phm_pkg::REG_MODULUS, new_mod);
            write_reg(phm_pkg::REG_BASE, pick_base(new_mod));
            items_left = PHASE_ITEMS;
            while (items_left > 0) begin
                burst = $urandom_range(1, 40);
                if (burst > items_left) begin
                    burst = items_left;
                end
                repeat (burst) send_item(VEC_W'($urandom_range(0, 31)), 1'b0, '0);
                items_left -= burst;
                if ($urandom_range(0, 15) == 0) begin
                    // Let the whole pipeline empty before going on.
                    stop_sending();
                    drain_results();
                end else begin
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    if (gap > 0) begin
                        stop_sending();
                        repeat (gap) @(posedge aclk);
                    end
                end
            end
        end

        stop_sending();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (hash_expected_q.size() != 0) begin
            log_failure($sformatf("%0d expected results never arrived",
                                  hash_expected_q.size()));
        end

        $display("Sent %0d items under %0d register writes, checked %0d hashes.",
                 items_sent, settings_used - 1, results_checked);
        $display("Mismatches and other failures: %0d.", errors);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
